// ===== hdl/carl_pkg.sv =====
// Shared types and constants for the column affine linear resampler.
// No dependencies; used by the front, back and top-level files.
package carl_pkg;

  localparam int IDX_W    = 8;                      // row and column fields
  localparam int PIX_W    = 16;                     // pixel width
  localparam int STEP_W   = 32;                     // Q16.16 step registers
  localparam int SIZE_W   = 9;                      // size register
  localparam int PROD_W   = IDX_W + STEP_W + 1;     // index times step
  localparam int Y_W      = IDX_W + STEP_W + 2;     // full source row position
  localparam int CFG_IDX_W = 2;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [0:0] {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    REGION_INTERP  = 2'd0,
    REGION_FIRST   = 2'd1,
    REGION_LAST    = 2'd2,
    REGION_OUTSIDE = 2'd3
  } region_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE   = 2'd0,
    CFG_SCALE  = 2'd1,
    CFG_SHEAR  = 2'd2,
    CFG_OFFSET = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic signed [STEP_W-1:0] scale;
    logic signed [STEP_W-1:0] shear;
    logic signed [STEP_W-1:0] offset;
  } steps_t;

endpackage

// ===== hdl/carl_front.sv =====
// Front end: accepts items, forms the source row position and classifies it.
// Depends on carl_pkg; pushes packed entries into carl_queue.
module carl_front #(
  parameter int MAX_SIZE  = 256,
  parameter int FRAC_BITS = 16,
  localparam int RW = $clog2(MAX_SIZE),
  localparam int SW = $clog2(MAX_SIZE + 1),
  localparam int EW = 1 + 2 + 3 * RW + FRAC_BITS + carl_pkg::PIX_W
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_type,
  input  logic [carl_pkg::IDX_W-1:0]        in_row,
  input  logic [carl_pkg::IDX_W-1:0]        in_col,
  input  logic signed [carl_pkg::PIX_W-1:0] in_pixel,
  input  logic [SW-1:0]                     side,
  input  carl_pkg::steps_t                  steps,
  input  logic                              q_full,
  output logic                              push,
  output logic [EW-1:0]                     entry
);

  localparam int YW = carl_pkg::Y_W;

  logic adv;

  // stage 1: products
  logic                              f1_valid;
  logic                              f1_type;
  logic                              f1_keep;
  logic [carl_pkg::IDX_W-1:0]        f1_row;
  logic [carl_pkg::IDX_W-1:0]        f1_col;
  logic signed [carl_pkg::PIX_W-1:0] f1_pixel;
  logic signed [carl_pkg::PROD_W-1:0] f1_prow;
  logic signed [carl_pkg::PROD_W-1:0] f1_pcol;

  // stage 2: position
  logic                              f2_valid;
  logic                              f2_type;
  logic                              f2_keep;
  logic [carl_pkg::IDX_W-1:0]        f2_row;
  logic [carl_pkg::IDX_W-1:0]        f2_col;
  logic signed [carl_pkg::PIX_W-1:0] f2_pixel;
  logic signed [YW-1:0]              f2_y;
  logic                              f2_colout;

  // stage 3: compare flags
  logic                              f3_valid;
  logic                              f3_type;
  logic                              f3_keep;
  logic [carl_pkg::IDX_W-1:0]        f3_row;
  logic [carl_pkg::IDX_W-1:0]        f3_col;
  logic signed [carl_pkg::PIX_W-1:0] f3_pixel;
  logic                              f3_colout;
  logic                              f3_ge_nh;
  logic                              f3_le_zero;
  logic                              f3_ge_lim1;
  logic                              f3_le_lim2;
  logic [RW-1:0]                     f3_r;
  logic [FRAC_BITS-1:0]              f3_frac;

  logic signed [YW-1:0] half;
  logic signed [YW-1:0] neg_half;
  logic signed [YW-1:0] lim1;
  logic signed [YW-1:0] lim2;
  logic                 in_keep;

  carl_pkg::region_t    code;
  logic [RW-1:0]        row_a;
  logic [RW-1:0]        row_b;
  logic [RW-1:0]        last_row;
  logic                 is_write;

  // stall the whole front only when a kept item cannot enter the queue
  assign adv      = !(f3_valid && f3_keep) || !q_full;
  assign in_ready = adv;
  assign push     = f3_valid && f3_keep && adv;

  assign in_keep = (in_type == carl_pkg::REQ_QUERY) ||
                   ((int'(in_row) < MAX_SIZE) && (int'(in_col) < MAX_SIZE));

  assign half     = YW'(1) <<< (FRAC_BITS - 1);
  assign neg_half = -half;
  assign lim1     = $signed(YW'(side - SW'(1)) << FRAC_BITS);
  assign lim2     = lim1 + half;
  assign last_row = RW'(side - SW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
      f3_valid <= 1'b0;
    end else if (adv) begin
      f1_valid <= in_valid;
      f2_valid <= f1_valid;
      f3_valid <= f2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_type  <= in_type;
      f1_keep  <= in_keep;
      f1_row   <= in_row;
      f1_col   <= in_col;
      f1_pixel <= in_pixel;
      f1_prow  <= $signed({1'b0, in_row}) * steps.scale;
      f1_pcol  <= $signed({1'b0, in_col}) * steps.shear;

      f2_type   <= f1_type;
      f2_keep   <= f1_keep;
      f2_row    <= f1_row;
      f2_col    <= f1_col;
      f2_pixel  <= f1_pixel;
      f2_y      <= steps.offset + f1_prow - f1_pcol;
      f2_colout <= int'(f1_col) >= int'(side);

      f3_type    <= f2_type;
      f3_keep    <= f2_keep;
      f3_row     <= f2_row;
      f3_col     <= f2_col;
      f3_pixel   <= f2_pixel;
      f3_colout  <= f2_colout;
      f3_ge_nh   <= f2_y >= neg_half;
      f3_le_zero <= f2_y[YW-1] || (f2_y == '0);
      f3_ge_lim1 <= f2_y >= lim1;
      f3_le_lim2 <= f2_y <= lim2;
      f3_r       <= f2_y[FRAC_BITS +: RW];
      f3_frac    <= f2_y[FRAC_BITS-1:0];
    end
  end

  assign is_write = (f3_type == carl_pkg::REQ_WRITE);

  always_comb begin
    priority if (f3_colout) begin
      code = carl_pkg::REGION_OUTSIDE;
    end else if (f3_ge_nh && f3_le_zero) begin
      code = carl_pkg::REGION_FIRST;
    end else if (f3_ge_lim1 && f3_le_lim2) begin
      code = carl_pkg::REGION_LAST;
    end else if (!f3_ge_nh || !f3_le_lim2) begin
      code = carl_pkg::REGION_OUTSIDE;
    end else begin
      code = carl_pkg::REGION_INTERP;
    end
  end

  always_comb begin
    if (is_write) begin
      row_a = RW'(f3_row);
    end else begin
      unique case (code)
        carl_pkg::REGION_FIRST:   row_a = '0;
        carl_pkg::REGION_LAST:    row_a = last_row;
        carl_pkg::REGION_INTERP:  row_a = f3_r;
        carl_pkg::REGION_OUTSIDE: row_a = '0;
        default:                  row_a = '0;
      endcase
    end
    row_b = f3_r + RW'(1);
  end

  assign entry = {is_write, code, RW'(f3_col), row_a, row_b, f3_frac, f3_pixel};

endmodule

// ===== hdl/carl_queue.sv =====
// Short register queue between the front and back halves of the resampler.
// No package dependency; width and depth come from parameters.
module carl_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = slots[rptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_data;
    end
  end

endmodule

// ===== hdl/carl_back.sv =====
// Back end: image memory, two-row fetch, linear blend and output register.
// Depends on carl_pkg; pops packed entries from carl_queue.
module carl_back #(
  parameter int MAX_SIZE  = 256,
  parameter int FRAC_BITS = 16,
  localparam int RW = $clog2(MAX_SIZE),
  localparam int EW = 1 + 2 + 3 * RW + FRAC_BITS + carl_pkg::PIX_W
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              head_valid,
  input  logic [EW-1:0]                     head_data,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [carl_pkg::PIX_W-1:0] out_pixel,
  output carl_pkg::region_t                 out_region
);

  localparam int PIX_W = carl_pkg::PIX_W;
  localparam int DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int SUM_W = FRAC_BITS + PIX_W + 2;

  logic                    e_write;
  logic [1:0]              e_code;
  logic [RW-1:0]           e_col;
  logic [RW-1:0]           e_row_a;
  logic [RW-1:0]           e_row_b;
  logic [FRAC_BITS-1:0]    e_frac;
  logic [PIX_W-1:0]        e_pixel;
  logic [AW-1:0]           addr_a;
  logic [AW-1:0]           addr_b;
  logic                    adv;

  logic [PIX_W-1:0]        image_mem [DEPTH];

  logic                    s2_valid;
  carl_pkg::region_t       s2_code;
  logic [FRAC_BITS-1:0]    s2_frac;
  logic signed [PIX_W-1:0] s2_p0;
  logic signed [PIX_W-1:0] s2_p1;

  logic                    s3_valid;
  carl_pkg::region_t       s3_code;
  logic [FRAC_BITS-1:0]    s3_frac;
  logic signed [PIX_W-1:0] s3_p0;
  logic signed [PIX_W:0]   s3_diff;

  logic                    s4_valid;
  carl_pkg::region_t       s4_code;
  logic signed [PIX_W-1:0] s4_p0;
  logic signed [SUM_W-1:0] s4_prod;

  logic                    s5_valid;
  carl_pkg::region_t       s5_code;
  logic signed [PIX_W-1:0] s5_p0;
  logic signed [SUM_W-1:0] s5_sum;

  logic signed [SUM_W-1:0] p0_ext;
  logic                    round_up;
  logic signed [PIX_W-1:0] blend;
  logic signed [PIX_W-1:0] pixel_sel;

  assign {e_write, e_code, e_col, e_row_a, e_row_b, e_frac, e_pixel} = head_data;

  assign addr_a = AW'(e_row_a * MAX_SIZE + e_col);
  assign addr_b = AW'(e_row_b * MAX_SIZE + e_col);

  // every stage moves together; the output register is the only stall point
  assign adv = !out_valid || out_ready;
  assign pop = adv && head_valid;

  always_ff @(posedge clk) begin
    if (pop && e_write) begin
      image_mem[addr_a] <= e_pixel;
    end
    if (adv) begin
      s2_p0 <= $signed(image_mem[addr_a]);
      s2_p1 <= $signed(image_mem[addr_b]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s2_valid  <= head_valid && !e_write;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      s5_valid  <= s4_valid;
      out_valid <= s5_valid;
    end
  end

  assign p0_ext   = SUM_W'(s4_p0) <<< FRAC_BITS;
  // truncate toward zero: bump negative sums that have a fraction left
  assign round_up = s5_sum[SUM_W-1] && (s5_sum[FRAC_BITS-1:0] != '0);
  assign blend    = s5_sum[FRAC_BITS +: PIX_W] + PIX_W'(round_up);

  always_comb begin
    unique case (s5_code)
      carl_pkg::REGION_INTERP:  pixel_sel = blend;
      carl_pkg::REGION_FIRST:   pixel_sel = s5_p0;
      carl_pkg::REGION_LAST:    pixel_sel = s5_p0;
      carl_pkg::REGION_OUTSIDE: pixel_sel = '0;
      default:                  pixel_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_code <= carl_pkg::region_t'(e_code);
      s2_frac <= e_frac;

      s3_code <= s2_code;
      s3_frac <= s2_frac;
      s3_p0   <= s2_p0;
      s3_diff <= (PIX_W+1)'(s2_p1) - (PIX_W+1)'(s2_p0);

      s4_code <= s3_code;
      s4_p0   <= s3_p0;
      s4_prod <= $signed({1'b0, s3_frac}) * s3_diff;

      s5_code <= s4_code;
      s5_p0   <= s4_p0;
      s5_sum  <= p0_ext + s4_prod;

      out_pixel  <= pixel_sel;
      out_region <= s5_code;
    end
  end

endmodule

// ===== hdl/column_affine_linear_resampler.sv =====
// Top level of the column affine linear resampler: configuration registers
// and the front, queue and back halves. Depends on carl_pkg and all submodules.
//
// Input stream s_*: tuser selects a pixel write (0) or a query (1). A write
// stores pixel_in at row_index, column_index and gives no result; a query
// returns one beat on m_* with the pixel resampled along the row axis for
// output row row_index, column column_index, and its region code in tuser.
// Configuration writes on cfg_* are taken every cycle and must happen only
// while no item is in flight.
// A query passes through three front stages, the queue, four back stages and
// the output register before its result shows on m_*.
// Throughput: one item per cycle while m_tready and the queue let the front
// advance, set by the write and dual-read image memory port in the back half.
// Reset clears the pipeline and the queue and loads the default registers
// (side 256, unit scale, no shear, zero offset); the image memory is not
// cleared and a query must only touch pixels already written.
// When m_tready is low the back half holds; the queue absorbs the front half
// until it fills, and only then does s_tready drop.
module column_affine_linear_resampler #(
  parameter int MAX_SIZE  = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [31:0]                       s_tdata,  // row_index, column_index, pixel_in
  input  logic [0:0]                        s_tuser,  // req_type
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [15:0]                       m_tdata,  // pixel_out
  output logic [1:0]                        m_tuser,  // region_code
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [carl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                       cfg_data
);

  localparam int RW = $clog2(MAX_SIZE);
  localparam int SW = $clog2(MAX_SIZE + 1);
  localparam int EW = 1 + 2 + 3 * RW + FRAC_BITS + carl_pkg::PIX_W;

  logic [carl_pkg::SIZE_W-1:0] size_in_use;
  carl_pkg::steps_t            steps;
  logic [SW-1:0]               side;

  logic                        push;
  logic [EW-1:0]               entry;
  logic                        q_full;
  logic                        pop;
  logic                        head_valid;
  logic [EW-1:0]               head_data;
  logic signed [15:0]          out_pixel;
  carl_pkg::region_t           out_region;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use  <= carl_pkg::SIZE_W'(256);
      steps.scale  <= 32'sd65536;
      steps.shear  <= '0;
      steps.offset <= '0;
    end else if (cfg_valid) begin
      unique case (carl_pkg::cfg_index_t'(cfg_index))
        carl_pkg::CFG_SIZE:   size_in_use  <= cfg_data[carl_pkg::SIZE_W-1:0];
        carl_pkg::CFG_SCALE:  steps.scale  <= $signed(cfg_data);
        carl_pkg::CFG_SHEAR:  steps.shear  <= $signed(cfg_data);
        carl_pkg::CFG_OFFSET: steps.offset <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // clamp the side length to the range 2 to MAX_SIZE
  always_comb begin
    priority if (int'(size_in_use) < 2) begin
      side = SW'(2);
    end else if (int'(size_in_use) > MAX_SIZE) begin
      side = SW'(MAX_SIZE);
    end else begin
      side = SW'(size_in_use);
    end
  end

  carl_front #(
    .MAX_SIZE  (MAX_SIZE),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_type  (s_tuser[0]),
    .in_row   (s_tdata[7:0]),
    .in_col   (s_tdata[15:8]),
    .in_pixel ($signed(s_tdata[31:16])),
    .side     (side),
    .steps    (steps),
    .q_full   (q_full),
    .push     (push),
    .entry    (entry)
  );

  carl_queue #(
    .WIDTH (EW),
    .DEPTH (carl_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  carl_back #(
    .MAX_SIZE  (MAX_SIZE),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_pixel  (out_pixel),
    .out_region (out_region)
  );

  assign m_tdata = out_pixel;
  assign m_tuser = out_region;

endmodule

// ===== dv/tb_column_affine_linear_resampler.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for column_affine_linear_resampler: loads pixels, issues
// row-axis resampling queries and compares every result beat against a scoreboard.
// Depends on carl_pkg and the column_affine_linear_resampler RTL.
module tb_column_affine_linear_resampler;

  localparam int     FRAC_BITS = 16;
  localparam int     MAX_SIDE  = 256;
  localparam longint ONE_Q     = 64'sd1 << FRAC_BITS;
  localparam longint HALF_Q    = 64'sd1 << (FRAC_BITS - 1);
  localparam int     LIMIT     = 400000;

  typedef struct {
    carl_pkg::region_t region;
    int                row_lo;
    longint            frac;
  } row_lookup_t;

  typedef struct packed {
    logic [15:0]       pixel;
    carl_pkg::region_t region;
  } pixel_beat_t;

  class resample_scoreboard;
    logic [15:0]        image  [0:MAX_SIDE*MAX_SIDE-1];
    bit                 loaded [0:MAX_SIDE*MAX_SIDE-1];
    logic [8:0]         size_reg;
    logic signed [31:0] scale_q, shear_q, offset_q;
    pixel_beat_t        pending_q [$];
    int                 errors;

    function new();
      size_reg = 9'd256;
      scale_q  = 32'sh0001_0000;
      shear_q  = '0;
      offset_q = '0;
      errors   = 0;
    endfunction

    function void set_reg(carl_pkg::cfg_index_t idx, logic [31:0] d);
      case (idx)
        carl_pkg::CFG_SIZE:   size_reg = d[8:0];
        carl_pkg::CFG_SCALE:  scale_q  = d;
        carl_pkg::CFG_SHEAR:  shear_q  = d;
        carl_pkg::CFG_OFFSET: offset_q = d;
        default: ;
      endcase
    endfunction

    function int side();
      int s;
      s = size_reg;
      if (s < 2) s = 2;
      if (s > MAX_SIDE) s = MAX_SIDE;
      return s;
    endfunction

    // Classify the source row position and pick the rows it reads.
    function row_lookup_t lookup(int row, int col);
      row_lookup_t lk;
      longint      y, lim1;
      int          s;
      s = side();
      lk.row_lo = 0;
      lk.frac = 0;
      y = longint'(offset_q) + longint'(row) * longint'(scale_q)
          - longint'(col) * longint'(shear_q);
      lim1 = longint'(s - 1) * ONE_Q;
      if (col >= s) begin
        lk.region = carl_pkg::REGION_OUTSIDE;
      end else if (y >= -HALF_Q && y <= 0) begin
        lk.region = carl_pkg::REGION_FIRST;
      end else if (y >= lim1 && y <= lim1 + HALF_Q) begin
        lk.region = carl_pkg::REGION_LAST;
        lk.row_lo = s - 1;
      end else if (y < -HALF_Q || y > lim1 + HALF_Q) begin
        lk.region = carl_pkg::REGION_OUTSIDE;
      end else begin
        lk.region = carl_pkg::REGION_INTERP;
        lk.row_lo = int'(y / ONE_Q);
        lk.frac = y - longint'(lk.row_lo) * ONE_Q;
      end
      return lk;
    endfunction

    function longint pixel_at(int row, int col);
      return longint'($signed(image[row*MAX_SIDE + col]));
    endfunction

    function void note_input(carl_pkg::req_t req, int row, int col, logic [15:0] pix);
      row_lookup_t lk;
      pixel_beat_t b;
      longint      p0, p1, v;
      if (req == carl_pkg::REQ_WRITE) begin
        image[row*MAX_SIDE + col] = pix;
        loaded[row*MAX_SIDE + col] = 1'b1;
        return;
      end
      lk = lookup(row, col);
      b.region = lk.region;
      case (lk.region)
        carl_pkg::REGION_FIRST, carl_pkg::REGION_LAST:
          b.pixel = image[lk.row_lo*MAX_SIDE + col];
        carl_pkg::REGION_INTERP: begin
          p0 = pixel_at(lk.row_lo, col);
          p1 = pixel_at(lk.row_lo + 1, col);
          // signed division truncates toward zero
          v = (p0 * ONE_Q + lk.frac * (p1 - p0)) / ONE_Q;
          b.pixel = v[15:0];
        end
        default: b.pixel = '0;
      endcase
      pending_q.push_back(b);
    endfunction

    function void check_result(logic [15:0] pix, logic [1:0] code);
      pixel_beat_t b;
      if (pending_q.size() == 0) begin
        $error("result beat with no query outstanding: pixel_out %0d region_code %0d",
               $signed(pix), code);
        errors++;
        return;
      end
      b = pending_q.pop_front();
      if (pix !== b.pixel) begin
        $error("pixel_out expected %0d got %0d", $signed(b.pixel), $signed(pix));
        errors++;
      end
      if (code !== b.region) begin
        $error("region_code expected %0d got %0d", b.region, code);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata   = '0;
  logic [0:0]  s_tuser   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [carl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data  = '0;

  int src_idle = 7;
  int snk_idle = 67;
  int cycles   = 0;

  resample_scoreboard sb;

  column_affine_linear_resampler dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("column_affine_linear_resampler verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_idle);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  function automatic logic [15:0] rand_pixel();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_beat(carl_pkg::req_t req, int row, int col, logic [15:0] pix);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {pix, 8'(col), 8'(row)};
    do @(posedge clk); while (!s_tready);
    sb.note_input(req, row, col, pix);
  endtask

  // Load a pixel the query will read, unless it already holds a value.
  task automatic ensure_loaded(int row, int col);
    if (!sb.loaded[row*MAX_SIDE + col])
      send_beat(carl_pkg::REQ_WRITE, row, col, rand_pixel());
  endtask

  task automatic query_pixel(int row, int col);
    row_lookup_t lk;
    lk = sb.lookup(row, col);
    if (lk.region != carl_pkg::REGION_OUTSIDE) ensure_loaded(lk.row_lo, col);
    if (lk.region == carl_pkg::REGION_INTERP) ensure_loaded(lk.row_lo + 1, col);
    send_beat(carl_pkg::REQ_QUERY, row, col, rand_pixel());
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending_q.size() > 0);
  endtask

  // Drain, then give trailing pixel writes time to leave the pipeline.
  task automatic settle();
    drain_results();
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(carl_pkg::cfg_index_t idx, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, d);
  endtask

  task automatic program_regs(logic [31:0] sz, logic [31:0] sc, logic [31:0] sh,
                              logic [31:0] of);
    write_reg(carl_pkg::CFG_SIZE, sz);
    write_reg(carl_pkg::CFG_SCALE, sc);
    write_reg(carl_pkg::CFG_SHEAR, sh);
    write_reg(carl_pkg::CFG_OFFSET, of);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_config(int k);
    int          size_list [8];
    int          s;
    logic [31:0] sz, sc, sh, of;
    size_list = '{2, 5, 16, 1, 511, 256, 3, 9};
    sz = size_list[k];
    s = (sz < 2) ? 2 : ((sz > MAX_SIDE) ? MAX_SIDE : sz);
    case (k)
      2: begin
        sc = 32'h8000_0000;
        sh = 32'h7FFF_FFFF;
        of = 32'h7FFF_FFFF;
      end
      6: begin
        sc = 32'h7FFF_FFFF;
        sh = 32'h8000_0000;
        of = 32'h8000_0000;
      end
      4: begin
        sc = $urandom();
        sh = $urandom();
        of = $urandom();
      end
      default: begin
        // keep y mostly inside the image so interpolation dominates
        sc = $urandom_range(0, 3 * int'(ONE_Q) / 2);
        if ($urandom_range(3) == 0) sc = -sc;
        of = int'($urandom_range(0, s * int'(ONE_Q))) - int'(HALF_Q);
        sh = int'($urandom_range(0, int'(HALF_Q))) - int'(HALF_Q) / 2;
      end
    endcase
    program_regs(sz, sc, sh, of);
  endtask

  initial begin
    int ph, i, span;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: y = row exactly, so rows 0 and 255 are the edge copies.
    send_beat(carl_pkg::REQ_WRITE, 0, 0, 16'h8000);
    send_beat(carl_pkg::REQ_WRITE, 255, 0, 16'h7FFF);
    send_beat(carl_pkg::REQ_WRITE, 255, 255, 16'hFFFF);
    send_beat(carl_pkg::REQ_WRITE, 0, 255, 16'h7FFF);
    query_pixel(0, 0);
    query_pixel(255, 0);
    query_pixel(255, 255);
    query_pixel(0, 255);
    send_beat(carl_pkg::REQ_WRITE, 128, 7, 16'h7FFF);
    send_beat(carl_pkg::REQ_WRITE, 129, 7, 16'h8000);
    query_pixel(128, 7);

    // Side 8, half-row scale, quarter-row shear, offset -0.25: hit each boundary.
    settle();
    program_regs(32'd8, 32'h0000_8000, 32'h0000_4000, 32'hFFFF_C000);
    send_beat(carl_pkg::REQ_WRITE, 0, 0, 16'h8000);
    send_beat(carl_pkg::REQ_WRITE, 1, 0, 16'h7FFF);
    query_pixel(1, 0);     // negative blend, truncated toward zero
    query_pixel(0, 0);
    query_pixel(0, 1);     // exactly minus one half
    query_pixel(0, 2);     // just below the top margin
    query_pixel(1, 1);     // exactly zero
    query_pixel(15, 0);
    query_pixel(15, 1);    // exactly the last row
    query_pixel(16, 1);    // last row plus one half
    query_pixel(17, 2);    // past the bottom margin
    query_pixel(3, 8);     // column beyond the side

    for (ph = 0; ph < 8; ph++) begin
      if (ph == 3) begin
        src_idle = 67;
        snk_idle = 7;
      end
      if (ph == 6) begin
        src_idle = 0;
        snk_idle = 0;
      end
      settle();
      random_config(ph);
      span = (sb.side() + 2 > 255) ? 255 : sb.side() + 2;
      for (i = 0; i < 50; i++) begin
        if (ph == 1 && i == 25) drain_results();
        if ($urandom_range(99) < 20)
          send_beat(carl_pkg::REQ_WRITE, $urandom_range(255), $urandom_range(255),
                    rand_pixel());
        else if ($urandom_range(9) == 0)
          query_pixel($urandom_range(255), $urandom_range(255));
        else
          query_pixel($urandom_range(span), $urandom_range(span));
      end
    end

    settle();
    if (sb.errors == 0) begin
      $display("column_affine_linear_resampler verification clean");
    end else begin
      $display("column_affine_linear_resampler verification failed");
    end
    $finish;
  end

endmodule
